FILE: design/tpml_pkg.sv
package tpml_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int OFFSET_BITS_DEF = 24;

  // fixed field widths
  localparam int PATTERN_BYTES = 16;
  localparam int LEN_W = 5;
  localparam int LINE_W = 20;
  localparam int COL_W = 16;
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0] COL_MAX = '1;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0a;

  // register indexes (byte address 8*index)
  localparam logic [1:0] REG_PATTERN_LOW = 2'd0;
  localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

  // one window slot: text byte with the place it had
  typedef struct packed {
    logic              valid;
    logic [7:0]        data;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
  } slot_t;

  function automatic logic [7:0] pattern_byte(logic [63:0] lo, logic [63:0] hi,
                                              logic [3:0] k);
    logic [63:0] half;
    half = k[3] ? hi : lo;
    return half[8*k[2:0] +: 8];
  endfunction

endpackage

FILE: design/tpml_text_if.sv
interface tpml_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       start_of_text;

  modport source (output valid, output text_byte, output start_of_text, input ready);
  modport sink (input valid, input text_byte, input start_of_text, output ready);
endinterface

FILE: design/tpml_match_if.sv
interface tpml_match_if #(
  parameter int OFFSET_BITS = 24
);
  logic                   valid;
  logic                   ready;
  logic                   match_found;
  logic [OFFSET_BITS-1:0] match_offset;
  logic [19:0]            match_line;
  logic [15:0]            match_column;

  modport source (output valid, output match_found, output match_offset,
                  output match_line, output match_column, input ready);
  modport sink (input valid, input match_found, input match_offset,
                input match_line, input match_column, output ready);
endinterface

FILE: design/tpml_cell.sv
module tpml_cell
  import tpml_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic       clear,
  input  slot_t      prev,
  input  logic [7:0] pat,
  input  logic       used,
  output slot_t      cur,
  output slot_t      nxt,
  output logic       hit
);

  slot_t slot;

  always_comb begin
    nxt = prev;
    if (clear) begin
      nxt.valid = 1'b0;
    end
  end

  // compare against the contents this slot takes on at the shift
  assign hit = !used || (nxt.valid && (nxt.data == pat));
  assign cur = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (shift) begin
      slot <= nxt;
    end
  end

endmodule

FILE: design/text_pattern_match_locator.sv
// a byte's result word is registered and shown in the cycle after the byte is taken
// throughput: one byte per cycle while no result is held, the window chain shifts once per byte and
// the compare of all pattern positions runs in parallel beside it
// a new byte is taken in the cycle the last result leaves; a held result stalls the input
// reset (rst, synchronous, active high) clears the pattern registers, the
// offset, line and column counters and the window valid bits
module text_pattern_match_locator
  import tpml_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  tpml_text_if.sink             text_in,
  tpml_match_if.source          match_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // configuration registers
  logic [63:0]      pattern_low;
  logic [63:0]      pattern_high;
  logic [LEN_W-1:0] pattern_length;

  logic       cfg_write;
  logic [1:0] reg_index;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_index = paddr[APB_ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low <= '0;
      pattern_high <= '0;
      pattern_length <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_PATTERN_LOW: pattern_low <= pwdata;
        REG_PATTERN_HIGH: pattern_high <= pwdata;
        REG_PATTERN_LENGTH: pattern_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_PATTERN_LOW: prdata = pattern_low;
      REG_PATTERN_HIGH: prdata = pattern_high;
      REG_PATTERN_LENGTH: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, pattern_length};
      default: prdata = '0;
    endcase
  end

  // a length of zero, or one longer than the pattern store or the chain, never matches
  logic len_ok;
  assign len_ok = (pattern_length != '0) && (int'(pattern_length) <= PATTERN_BYTES)
                  && (int'(pattern_length) <= PATTERN_MAX);

  // input handshake and text position counters
  logic accept;
  logic out_valid;
  logic sot;
  logic [7:0] in_byte;

  assign text_in.ready = !out_valid || match_out.ready;
  assign accept = text_in.valid && text_in.ready;
  assign sot = text_in.start_of_text;
  assign in_byte = text_in.text_byte;

  logic [OFFSET_BITS-1:0] byte_position;
  logic [LINE_W-1:0]      current_line;
  logic [COL_W-1:0]       current_column;

  // start of text restarts the place of this very byte
  logic [OFFSET_BITS-1:0] pos_base;
  logic [LINE_W-1:0]      line_base;
  logic [COL_W-1:0]       col_base;

  assign pos_base = sot ? '0 : byte_position;
  assign line_base = sot ? '0 : current_line;
  assign col_base = sot ? '0 : current_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      current_line <= '0;
      current_column <= '0;
    end else if (accept) begin
      byte_position <= pos_base + OFFSET_BITS'(1);
      if (in_byte == NEWLINE_CHAR) begin
        current_column <= '0;
        current_line <= (line_base == LINE_MAX) ? line_base : line_base + LINE_W'(1);
      end else begin
        current_line <= line_base;
        current_column <= (col_base == COL_MAX) ? col_base : col_base + COL_W'(1);
      end
    end
  end

  // window chain: cell 0 holds the newest byte, cell i the byte i places back
  slot_t            cur [PATTERN_MAX];
  slot_t            nxt [PATTERN_MAX];
  logic             hit [PATTERN_MAX];
  logic [7:0]       pat [PATTERN_MAX];
  logic             used [PATTERN_MAX];
  slot_t            head;

  always_comb begin
    head.valid = 1'b1;
    head.data = in_byte;
    head.line = line_base;
    head.column = col_base;
  end

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [3:0] pat_index;

    // cell i lines up with pattern byte length-1-i
    assign used[i] = len_ok && (i < int'(pattern_length));
    assign pat_index = 4'(pattern_length - LEN_W'(1) - LEN_W'(i));
    assign pat[i] = pattern_byte(pattern_low, pattern_high, pat_index);

    if (i == 0) begin : g_head
      tpml_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .clear (1'b0),
        .prev  (head),
        .pat   (pat[i]),
        .used  (used[i]),
        .cur   (cur[i]),
        .nxt   (nxt[i]),
        .hit   (hit[i])
      );
    end else begin : g_body
      tpml_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .clear (sot),
        .prev  (cur[i-1]),
        .pat   (pat[i]),
        .used  (used[i]),
        .cur   (cur[i]),
        .nxt   (nxt[i]),
        .hit   (hit[i])
      );
    end
  end

  // all used cells agree; the oldest used cell gives the start place
  logic              match;
  logic [LINE_W-1:0] start_line;
  logic [COL_W-1:0]  start_column;

  always_comb begin
    match = len_ok;
    start_line = '0;
    start_column = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      match = match && hit[i];
      if (used[i] && (i == int'(pattern_length) - 1)) begin
        start_line = nxt[i].line;
        start_column = nxt[i].column;
      end
    end
  end

  logic [OFFSET_BITS-1:0] start_offset;
  assign start_offset = pos_base - OFFSET_BITS'(pattern_length) + OFFSET_BITS'(1);

  // output register, one result word per byte
  logic                   found;
  logic [OFFSET_BITS-1:0] offset;
  logic [LINE_W-1:0]      line;
  logic [COL_W-1:0]       column;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (match_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found <= match;
      offset <= match ? start_offset : '0;
      line <= match ? start_line : '0;
      column <= match ? start_column : '0;
    end
  end

  assign match_out.valid = out_valid;
  assign match_out.match_found = found;
  assign match_out.match_offset = offset;
  assign match_out.match_line = line;
  assign match_out.match_column = column;

endmodule
